FILE: rtl/mmisf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmisf_pkg
// Shared widths, codes and defaults of the multi-mask inf/sup filter.
// ----------------------------------------------------------------------------
package mmisf_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int unsigned DEF_MAX_MASKS  = 8;
  localparam int unsigned DEF_MASK_SIZE  = 5;
  localparam int unsigned DEF_MAX_WIDTH  = 256;
  localparam int unsigned DEF_MAX_HEIGHT = 256;

  // Request field widths
  localparam int unsigned REQ_TYPE_W  = 2;
  localparam int unsigned MASK_IDX_W  = 3;
  localparam int unsigned MASK_ROW_W  = 3;
  localparam int unsigned MASK_BITS_W = 5;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned PIX_W       = 8;

  // Configuration register widths
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 9;
  localparam int unsigned DIM_REG_W  = 9;
  localparam int unsigned MCOUNT_W   = 4;
  localparam int unsigned FL_MODE_W  = 1;
  localparam int unsigned SL_MODE_W  = 2;
  localparam int unsigned RANK_W     = 3;

  // Internal arithmetic widths
  localparam int unsigned DIM_W   = 13;  // holds a size up to 4096
  localparam int unsigned COORD_W = 14;  // signed window coordinate
  localparam int unsigned MCMP_W  = 6;   // mask count compare width

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MODE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MODE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RANK_INDEX  = 3'd5;

  // Register reset values
  localparam logic [DIM_REG_W-1:0] RST_IMG_WIDTH   = 9'd256;
  localparam logic [DIM_REG_W-1:0] RST_IMG_HEIGHT  = 9'd256;
  localparam logic [MCOUNT_W-1:0]  RST_MASK_COUNT  = 4'd1;
  localparam logic [FL_MODE_W-1:0] RST_FIRST_MODE  = 1'b1;
  localparam logic [SL_MODE_W-1:0] RST_SECOND_MODE = 2'd0;
  localparam logic [RANK_W-1:0]    RST_RANK_INDEX  = 3'd0;

  // Request types
  localparam logic [REQ_TYPE_W-1:0] REQ_MASK   = 2'd0;
  localparam logic [REQ_TYPE_W-1:0] REQ_PIXEL  = 2'd1;
  localparam logic [REQ_TYPE_W-1:0] REQ_FILTER = 2'd2;

  // Reduction modes
  localparam logic [FL_MODE_W-1:0] FL_MIN = 1'b0;
  localparam logic [FL_MODE_W-1:0] FL_MAX = 1'b1;
  localparam logic [SL_MODE_W-1:0] SL_MIN = 2'd0;
  localparam logic [SL_MODE_W-1:0] SL_MAX = 2'd1;

  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

endpackage

FILE: rtl/mmisf_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmisf_if
// Request and result channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface mmisf_req_if;
  logic                               valid;
  logic                               ready;
  logic [mmisf_pkg::REQ_TYPE_W-1:0]  req_type;
  logic [mmisf_pkg::MASK_IDX_W-1:0]  mask_index;
  logic [mmisf_pkg::MASK_ROW_W-1:0]  mask_row;
  logic [mmisf_pkg::MASK_BITS_W-1:0] mask_row_bits;
  logic [mmisf_pkg::POS_W-1:0]       pix_x;
  logic [mmisf_pkg::POS_W-1:0]       pix_y;
  logic [mmisf_pkg::PIX_W-1:0]       pix_value;

  modport source (
    output valid, req_type, mask_index, mask_row, mask_row_bits, pix_x, pix_y, pix_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, mask_index, mask_row, mask_row_bits, pix_x, pix_y, pix_value,
    output ready
  );
endinterface

interface mmisf_res_if;
  logic                         valid;
  logic                         ready;
  logic [mmisf_pkg::PIX_W-1:0]  filtered_value;
  logic [mmisf_pkg::POS_W-1:0]  out_x;
  logic [mmisf_pkg::POS_W-1:0]  out_y;

  modport source (output valid, filtered_value, out_x, out_y, input ready);
  modport sink   (input valid, filtered_value, out_x, out_y, output ready);
endinterface

FILE: rtl/mmisf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmisf_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module mmisf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/multi_mask_inf_sup_filter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_mask_inf_sup_filter_core
// Multi-mask erosion/dilation with min, max or ranked combine across masks.
// ----------------------------------------------------------------------------
// Usage:
//  - req_i carries one request per handshake: load a mask row, load a pixel,
//    or filter a pixel. Only filter requests produce a result on res_o.
//  - Config is a plain write port (cfg_we_i/cfg_idx_i/cfg_wdata_i), to be
//    written by the user only while idle; the core does not enforce this.
//  - Pixel load: written on the accepting handshake. Mask row load: a
//    read-modify-write of the mask row shared by all masks, via ST_MASK_WR.
//  - Filter: an accept step, MASK_SIZE*MASK_SIZE window reads (25 at 5x5)
//    in ST_FILT, a drain step, then rank select over the lanes in turn, up
//    to mask_count candidates. The pixel RAM read port, one window pixel per
//    cycle, bounds the read phase; all masks update in parallel on each pixel.
//  - Result lands in an output register; a new request is taken while it
//    waits. A stalled receiver holds the core only at the final select step.
//  - Reset clears control state and restores the register defaults; pixel
//    and mask memories hold garbage until written (no clearing pass).
// ----------------------------------------------------------------------------
module multi_mask_inf_sup_filter_core #(
  parameter int unsigned MAX_MASKS  = mmisf_pkg::DEF_MAX_MASKS,
  parameter int unsigned MASK_SIZE  = mmisf_pkg::DEF_MASK_SIZE,
  parameter int unsigned MAX_WIDTH  = mmisf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = mmisf_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mmisf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mmisf_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  mmisf_req_if.sink                       req_i,
  mmisf_res_if.source                     res_o
);

  localparam int unsigned HALF      = (MASK_SIZE - 1) / 2;
  localparam int unsigned WIN_IW    = (MASK_SIZE > 1) ? $clog2(MASK_SIZE) : 1;
  localparam int unsigned LANE_IW   = (MAX_MASKS > 1) ? $clog2(MAX_MASKS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_MASKS + 1);
  localparam int unsigned MASK_W    = MAX_MASKS * MASK_SIZE;
  localparam int unsigned PIX_DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned PIX_AW    = $clog2(PIX_DEPTH);
  localparam int unsigned DIM_W     = mmisf_pkg::DIM_W;
  localparam int unsigned COORD_W   = mmisf_pkg::COORD_W;
  localparam int unsigned PIX_W     = mmisf_pkg::PIX_W;
  localparam int unsigned POS_W     = mmisf_pkg::POS_W;

  // FSM codes
  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE    = 3'd0;
  localparam logic [ST_W-1:0] ST_MASK_WR = 3'd1;
  localparam logic [ST_W-1:0] ST_FILT    = 3'd2;
  localparam logic [ST_W-1:0] ST_DRAIN   = 3'd3;
  localparam logic [ST_W-1:0] ST_RANK    = 3'd4;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [mmisf_pkg::DIM_REG_W-1:0] img_width_q, img_height_q;
  logic [mmisf_pkg::MCOUNT_W-1:0]  mask_count_q;
  logic [mmisf_pkg::FL_MODE_W-1:0] fl_mode_q;
  logic [mmisf_pkg::SL_MODE_W-1:0] sl_mode_q;
  logic [mmisf_pkg::RANK_W-1:0]    rank_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      img_width_q  <= mmisf_pkg::RST_IMG_WIDTH;
      img_height_q <= mmisf_pkg::RST_IMG_HEIGHT;
      mask_count_q <= mmisf_pkg::RST_MASK_COUNT;
      fl_mode_q    <= mmisf_pkg::RST_FIRST_MODE;
      sl_mode_q    <= mmisf_pkg::RST_SECOND_MODE;
      rank_idx_q   <= mmisf_pkg::RST_RANK_INDEX;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mmisf_pkg::CFG_IMG_WIDTH: begin
          img_width_q <= cfg_wdata_i[mmisf_pkg::DIM_REG_W-1:0];
        end
        mmisf_pkg::CFG_IMG_HEIGHT: begin
          img_height_q <= cfg_wdata_i[mmisf_pkg::DIM_REG_W-1:0];
        end
        mmisf_pkg::CFG_MASK_COUNT: begin
          mask_count_q <= cfg_wdata_i[mmisf_pkg::MCOUNT_W-1:0];
        end
        mmisf_pkg::CFG_FIRST_MODE: begin
          fl_mode_q <= cfg_wdata_i[mmisf_pkg::FL_MODE_W-1:0];
        end
        mmisf_pkg::CFG_SECOND_MODE: begin
          sl_mode_q <= cfg_wdata_i[mmisf_pkg::SL_MODE_W-1:0];
        end
        mmisf_pkg::CFG_RANK_INDEX: begin
          rank_idx_q <= cfg_wdata_i[mmisf_pkg::RANK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Saturated sizes: zero means one, oversize clips to the maximum
  logic [DIM_W-1:0] width_eff, height_eff;
  logic [CNT_W-1:0] n_eff, n_last, k_eff;

  always_comb begin
    if (img_width_q == '0) begin
      width_eff = DIM_W'(1);
    end else if (DIM_W'(img_width_q) > DIM_W'(MAX_WIDTH)) begin
      width_eff = DIM_W'(MAX_WIDTH);
    end else begin
      width_eff = DIM_W'(img_width_q);
    end

    if (img_height_q == '0) begin
      height_eff = DIM_W'(1);
    end else if (DIM_W'(img_height_q) > DIM_W'(MAX_HEIGHT)) begin
      height_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      height_eff = DIM_W'(img_height_q);
    end

    if (mask_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (mmisf_pkg::MCMP_W'(mask_count_q) > mmisf_pkg::MCMP_W'(MAX_MASKS)) begin
      n_eff = CNT_W'(MAX_MASKS);
    end else begin
      n_eff = CNT_W'(mask_count_q);
    end
    n_last = n_eff - CNT_W'(1);

    // Min and max are rank 0 and rank n-1; mode three acts as ranked
    case (sl_mode_q)
      mmisf_pkg::SL_MIN: k_eff = '0;
      mmisf_pkg::SL_MAX: k_eff = n_last;
      default: begin
        if (mmisf_pkg::MCMP_W'(rank_idx_q) < mmisf_pkg::MCMP_W'(n_eff)) begin
          k_eff = CNT_W'(rank_idx_q);
        end else begin
          k_eff = n_last;
        end
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [ST_W-1:0]             state_q, state_d;
  logic [WIN_IW-1:0]           row_q, row_d, col_q, col_d;
  logic [WIN_IW-1:0]           col_p_q;
  logic                        vld_p_q, vld_p_d;
  logic [LANE_IW-1:0]          rank_i_q, rank_i_d;
  logic [POS_W-1:0]            x_q, y_q;
  logic [mmisf_pkg::MASK_IDX_W-1:0] midx_q;
  logic [WIN_IW-1:0]           mrow_q;
  logic [MASK_SIZE-1:0]        mbits_q;

  logic req_acc;
  logic is_mask, is_pixel, is_filter;
  logic mask_ok, pixel_ok;

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_acc     = req_i.valid && req_i.ready;
  assign is_mask     = (req_i.req_type == mmisf_pkg::REQ_MASK);
  assign is_pixel    = (req_i.req_type == mmisf_pkg::REQ_PIXEL);
  assign is_filter   = (req_i.req_type == mmisf_pkg::REQ_FILTER);
  assign mask_ok     = (32'(req_i.mask_index) < MAX_MASKS) && (32'(req_i.mask_row) < MASK_SIZE);
  assign pixel_ok    = (32'(req_i.pix_x) < MAX_WIDTH) && (32'(req_i.pix_y) < MAX_HEIGHT);

  // Window position of the current read, and whether it lies inside the image in use
  logic signed [COORD_W-1:0] wx_s, wy_s;
  logic                      in_win;

  assign wx_s = signed'(COORD_W'(x_q)) + signed'(COORD_W'(col_q)) - signed'(COORD_W'(HALF));
  assign wy_s = signed'(COORD_W'(y_q)) + signed'(COORD_W'(row_q)) - signed'(COORD_W'(HALF));
  assign in_win = !wx_s[COORD_W-1] && !wy_s[COORD_W-1]
               && (wx_s < signed'(COORD_W'(width_eff)))
               && (wy_s < signed'(COORD_W'(height_eff)));

  // --------------------------------------------------------------------------
  // Memories: pixels, and mask rows (entry r holds row r of every mask)
  // --------------------------------------------------------------------------
  logic              pix_we;
  logic [PIX_AW-1:0] pix_waddr, pix_raddr;
  logic [PIX_W-1:0]  pix_rd;
  logic              mask_we;
  logic [WIN_IW-1:0] mask_raddr;
  logic [MASK_W-1:0] mask_rd, mask_wdata;

  assign pix_we    = req_acc && is_pixel && pixel_ok;
  assign pix_waddr = PIX_AW'(32'(req_i.pix_y) * MAX_WIDTH + 32'(req_i.pix_x));
  assign pix_raddr = PIX_AW'(32'(DIM_W'(wy_s)) * MAX_WIDTH + 32'(DIM_W'(wx_s)));

  mmisf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (pix_we),
    .waddr_i (pix_waddr),
    .wdata_i (req_i.pix_value),
    .raddr_i (pix_raddr),
    .rdata_o (pix_rd)
  );

  // Row read at request time, merged and written back the next cycle
  assign mask_raddr = (state_q == ST_FILT) ? row_q : WIN_IW'(req_i.mask_row);
  assign mask_we    = (state_q == ST_MASK_WR);

  always_comb begin
    mask_wdata = mask_rd;
    for (int m = 0; m < MAX_MASKS; m++) begin
      if (m == int'(midx_q)) begin
        mask_wdata[m*MASK_SIZE +: MASK_SIZE] = mbits_q;
      end
    end
  end

  mmisf_ram #(
    .WIDTH (MASK_W),
    .DEPTH (MASK_SIZE)
  ) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .waddr_i (mrow_q),
    .wdata_i (mask_wdata),
    .raddr_i (mask_raddr),
    .rdata_o (mask_rd)
  );

  // --------------------------------------------------------------------------
  // Per-mask accumulators, one lane per mask, all updated on each pixel
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0] lvl_q [MAX_MASKS];
  logic [PIX_W-1:0] lvl_d [MAX_MASKS];
  logic             take_max;

  assign take_max = (fl_mode_q == mmisf_pkg::FL_MAX);

  always_comb begin
    for (int m = 0; m < MAX_MASKS; m++) begin
      lvl_d[m] = lvl_q[m];
      if (req_acc && is_filter) begin
        lvl_d[m] = take_max ? mmisf_pkg::PIX_BLACK : mmisf_pkg::PIX_WHITE;
      end else if (vld_p_q && mask_rd[m*MASK_SIZE + int'(col_p_q)]) begin
        if (take_max ? (pix_rd > lvl_q[m]) : (pix_rd < lvl_q[m])) begin
          lvl_d[m] = pix_rd;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Rank select: candidate i wins when lt(i) <= k < lt(i) + eq(i)
  // --------------------------------------------------------------------------
  logic [PIX_W-1:0]     cand;
  logic [MAX_MASKS-1:0] lt_vec, eq_vec;
  logic [CNT_W:0]       lt_cnt, le_cnt;
  logic                 hit;

  assign cand = lvl_q[rank_i_q];

  always_comb begin
    for (int j = 0; j < MAX_MASKS; j++) begin
      lt_vec[j] = (j < int'(n_eff)) && (lvl_q[j] < cand);
      eq_vec[j] = (j < int'(n_eff)) && (lvl_q[j] == cand);
    end
  end

  assign lt_cnt = (CNT_W+1)'($countones(lt_vec));
  assign le_cnt = lt_cnt + (CNT_W+1)'($countones(eq_vec));
  assign hit    = (lt_cnt <= (CNT_W+1)'(k_eff)) && ((CNT_W+1)'(k_eff) < le_cnt);

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  logic             res_vld_q, res_vld_d;
  logic [PIX_W-1:0] res_val_q;
  logic [POS_W-1:0] res_x_q, res_y_q;
  logic             out_free, out_load;

  assign out_free  = !res_vld_q || res_o.ready;
  assign out_load  = (state_q == ST_RANK) && hit && out_free;
  assign res_vld_d = out_load ? 1'b1 : (res_o.ready ? 1'b0 : res_vld_q);

  assign res_o.valid          = res_vld_q;
  assign res_o.filtered_value = res_val_q;
  assign res_o.out_x          = res_x_q;
  assign res_o.out_y          = res_y_q;

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    col_d    = col_q;
    rank_i_d = rank_i_q;
    vld_p_d  = (state_q == ST_FILT) && in_win;

    case (state_q)
      ST_IDLE: begin
        if (req_acc && is_mask && mask_ok) begin
          state_d = ST_MASK_WR;
        end else if (req_acc && is_filter) begin
          state_d = ST_FILT;
          row_d   = '0;
          col_d   = '0;
        end
      end
      ST_MASK_WR: begin
        state_d = ST_IDLE;
      end
      ST_FILT: begin
        if (col_q == WIN_IW'(MASK_SIZE - 1)) begin
          col_d = '0;
          if (row_q == WIN_IW'(MASK_SIZE - 1)) begin
            state_d = ST_DRAIN;
          end else begin
            row_d = row_q + WIN_IW'(1);
          end
        end else begin
          col_d = col_q + WIN_IW'(1);
        end
      end
      ST_DRAIN: begin
        // last window pixel lands in the lanes this cycle
        state_d  = ST_RANK;
        rank_i_d = '0;
      end
      ST_RANK: begin
        if (hit) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          rank_i_d = rank_i_q + LANE_IW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      row_q     <= '0;
      col_q     <= '0;
      col_p_q   <= '0;
      vld_p_q   <= 1'b0;
      rank_i_q  <= '0;
      res_vld_q <= 1'b0;
      for (int m = 0; m < MAX_MASKS; m++) begin
        lvl_q[m] <= '0;
      end
    end else begin
      state_q   <= state_d;
      row_q     <= row_d;
      col_q     <= col_d;
      col_p_q   <= col_q;
      vld_p_q   <= vld_p_d;
      rank_i_q  <= rank_i_d;
      res_vld_q <= res_vld_d;
      lvl_q     <= lvl_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      x_q     <= req_i.pix_x;
      y_q     <= req_i.pix_y;
      midx_q  <= req_i.mask_index;
      mrow_q  <= WIN_IW'(req_i.mask_row);
      mbits_q <= MASK_SIZE'(req_i.mask_row_bits);
    end
    if (out_load) begin
      res_val_q <= cand;
      res_x_q   <= x_q;
      res_y_q   <= y_q;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_drain_to_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DRAIN) |=> (state_q == ST_RANK) && (rank_i_q == '0))
    else $error("rank select did not start at lane zero after drain");

  a_rank_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RANK) |-> (int'(rank_i_q) < int'(n_eff)))
    else $error("rank select ran past the masks in use");

  a_result_from_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_vld_q) |-> ($past(state_q) == ST_RANK))
    else $error("result raised outside rank select");

endmodule
